@@ hw/rtl/pft_pkg.sv @@
// ============================================================================
// pft_pkg: shared types, constants and tables for the pose frame transform
// Word formats, pipeline payloads and the CORDIC arctangent table.
// ============================================================================
`default_nettype none

package pft_pkg;

    // Design constants
    localparam int CORDIC_STEPS = 16;   // range 8..32
    localparam int ANGLE_BITS   = 16;   // range 12..24

    // Steps actually built (capped at the table depth)
    localparam int STEPS  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int STEP_W = 5;          // indexes the 32-entry table

    localparam int POS_W  = 32;         // Q16.16 position
    localparam int HD_W   = 16;         // binary angle
    localparam int DIFF_W = POS_W + 1;  // exact difference
    localparam int GAIN_W = 32;
    localparam int PROD_W = DIFF_W + GAIN_W;
    localparam int DW     = 52;         // datapath: Q16.32 plus headroom
    localparam int ZW     = ANGLE_BITS + 1;
    localparam int OW     = DW - 16;    // after the final rounding shift

    // 1/K CORDIC gain compensation, Q0.31
    localparam logic signed [GAIN_W-1:0] GAIN_Q31 = 32'sh4DBA76D4;

    localparam logic signed [OW-1:0] POS_MAX = OW'(64'sd2147483647);
    localparam logic signed [OW-1:0] POS_MIN = OW'(-64'sd2147483648);
    localparam logic signed [DW-1:0] ROUND_HALF = DW'(64'sd32768);

    // atan(2^-i) as a fraction of a turn, 32-bit
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Arctangent rounded half up to ANGLE_BITS
    function automatic logic [ANGLE_BITS-1:0] atan_ba(input logic [STEP_W-1:0] idx);
        logic [32:0] sum;
        sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - ANGLE_BITS));
        return sum[31 -: ANGLE_BITS];
    endfunction

    typedef struct packed {
        logic signed [POS_W-1:0] frame_x;
        logic signed [POS_W-1:0] frame_y;
        logic signed [HD_W-1:0]  frame_heading;
        logic signed [POS_W-1:0] point_x;
        logic signed [POS_W-1:0] point_y;
        logic signed [HD_W-1:0]  point_heading;
    } t_pose_in;

    typedef struct packed {
        logic signed [POS_W-1:0] local_x;
        logic signed [POS_W-1:0] local_y;
        logic signed [HD_W-1:0]  local_heading;
        logic                    saturated;
    } t_pose_out;

    // Rotation pipeline payload
    typedef struct packed {
        logic signed [DW-1:0]   x;
        logic signed [DW-1:0]   y;
        logic signed [ZW-1:0]   z;
        logic signed [HD_W-1:0] hd;
    } t_rot;

endpackage

`default_nettype wire

@@ hw/rtl/pft_channels.sv @@
// ============================================================================
// pft_channels: valid/ready channels of the pose frame transform
// Input pose channel and local pose channel.
// ============================================================================
`default_nettype none

interface pft_in_if;
    logic              valid;
    logic              ready;
    pft_pkg::t_pose_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pft_out_if;
    logic               valid;
    logic               ready;
    pft_pkg::t_pose_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pft_front.sv @@
// ============================================================================
// pft_front: difference, gain multiply and quadrant fold
// Three register stages ahead of the CORDIC micro-rotations.
// ============================================================================
`default_nettype none

module pft_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire pft_pkg::t_pose_in i_pose,
    output logic                   o_ready,
    output logic                   o_valid,
    output pft_pkg::t_rot          o_rot,
    input  wire logic              i_ready
);
    import pft_pkg::*;

    // stage 1: differences and angle
    logic                         r_v1;
    logic signed [DIFF_W-1:0]     r_dx, r_dy;
    logic [ANGLE_BITS-1:0]        r_z1;
    logic signed [HD_W-1:0]       r_hd1;
    // stage 2: gain product, folded angle
    logic                         r_v2;
    logic signed [PROD_W-1:0]     r_px, r_py;
    logic [ANGLE_BITS-1:0]        r_z2;
    logic                         r_neg;
    logic signed [HD_W-1:0]       r_hd2;
    // stage 3: datapath vector
    logic                         r_v3;
    t_rot                         r_rot;

    logic                         rdy1, rdy2, rdy3;
    logic [HD_W-1:0]              theta;
    logic [HD_W+23:0]             theta_wide;
    logic                         fold;
    logic signed [PROD_W-1:0]     sx, sy;
    logic signed [DW-1:0]         tx, ty;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // -frame_heading, aligned to ANGLE_BITS (left shift or floor right shift)
    assign theta      = HD_W'(-i_pose.frame_heading);
    assign theta_wide = {theta, 24'd0};

    // beyond a quarter turn: top two bits differ
    assign fold = r_z1[ANGLE_BITS-1] ^ r_z1[ANGLE_BITS-2];

    assign sx = r_px >>> 15;
    assign sy = r_py >>> 15;
    assign tx = sx[DW-1:0];
    assign ty = sy[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_dx  <= DIFF_W'(i_pose.point_x) - DIFF_W'(i_pose.frame_x);
            r_dy  <= DIFF_W'(i_pose.point_y) - DIFF_W'(i_pose.frame_y);
            r_z1  <= theta_wide[HD_W+23 -: ANGLE_BITS];
            r_hd1 <= i_pose.point_heading - i_pose.frame_heading;
        end
        if (rdy2 && r_v1) begin
            r_px  <= r_dx * GAIN_Q31;
            r_py  <= r_dy * GAIN_Q31;
            r_neg <= fold;
            r_z2  <= fold ? {~r_z1[ANGLE_BITS-1], r_z1[ANGLE_BITS-2:0]} : r_z1;
            r_hd2 <= r_hd1;
        end
        if (rdy3 && r_v2) begin
            r_rot.x  <= r_neg ? -tx : tx;
            r_rot.y  <= r_neg ? -ty : ty;
            r_rot.z  <= ZW'(signed'(r_z2));
            r_rot.hd <= r_hd2;
        end
    end

    assign o_valid = r_v3;
    assign o_rot   = r_rot;

    // folded angle lies within a quarter turn
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_rot.z[ANGLE_BITS-1] == r_rot.z[ANGLE_BITS-2]))
        else $error("folded angle outside a quarter turn");

endmodule

`default_nettype wire

@@ hw/rtl/pft_cordic_stage.sv @@
// ============================================================================
// pft_cordic_stage: one CORDIC micro-rotation, rotation mode
// Shift-add on x and y, arctangent step on z, one register stage.
// ============================================================================
`default_nettype none

module pft_cordic_stage (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [pft_pkg::STEP_W-1:0]   i_step,
    input  wire logic                         i_valid,
    input  wire pft_pkg::t_rot                i_rot,
    output logic                              o_ready,
    output logic                              o_valid,
    output pft_pkg::t_rot                     o_rot,
    input  wire logic                         i_ready
);
    import pft_pkg::*;

    logic                 r_valid;
    t_rot                 r_rot;
    t_rot                 n_rot;
    logic signed [DW-1:0] xs, ys;
    logic signed [ZW-1:0] a;

    assign o_ready = !r_valid || i_ready;

    assign xs = i_rot.x >>> i_step;
    assign ys = i_rot.y >>> i_step;
    assign a  = signed'({1'b0, atan_ba(i_step)});

    always_comb begin
        n_rot.hd = i_rot.hd;
        if (!i_rot.z[ZW-1]) begin
            n_rot.x = i_rot.x - ys;
            n_rot.y = i_rot.y + xs;
            n_rot.z = i_rot.z - a;
        end else begin
            n_rot.x = i_rot.x + ys;
            n_rot.y = i_rot.y - xs;
            n_rot.z = i_rot.z + a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;

endmodule

`default_nettype wire

@@ hw/rtl/pft_back.sv @@
// ============================================================================
// pft_back: round to Q16.16 and saturate
// Output register stage of the transform.
// ============================================================================
`default_nettype none

module pft_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire pft_pkg::t_rot      i_rot,
    output logic                    o_ready,
    output logic                    o_valid,
    output pft_pkg::t_pose_out      o_data,
    input  wire logic               i_ready
);
    import pft_pkg::*;

    logic                 r_valid;
    t_pose_out            r_data;
    logic signed [DW-1:0] rx, ry;
    logic signed [OW-1:0] qx, qy;
    logic                 hix, lox, hiy, loy;

    assign o_ready = !r_valid || i_ready;

    // floor((v + 2^15) / 2^16)
    assign rx = i_rot.x + ROUND_HALF;
    assign ry = i_rot.y + ROUND_HALF;
    assign qx = rx[DW-1:16];
    assign qy = ry[DW-1:16];

    assign hix = qx > POS_MAX;
    assign lox = qx < POS_MIN;
    assign hiy = qy > POS_MAX;
    assign loy = qy < POS_MIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.local_x       <= hix ? POS_MAX[POS_W-1:0] :
                                    lox ? POS_MIN[POS_W-1:0] : qx[POS_W-1:0];
            r_data.local_y       <= hiy ? POS_MAX[POS_W-1:0] :
                                    loy ? POS_MIN[POS_W-1:0] : qy[POS_W-1:0];
            r_data.local_heading <= i_rot.hd;
            r_data.saturated     <= hix || lox || hiy || loy;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ hw/rtl/pose_frame_transform.sv @@
// ============================================================================
// pose_frame_transform: global pose expressed in a reference frame
// Subtracts the frame origin, rotates by minus the frame heading with a
// gain-compensated pipelined CORDIC, wraps the heading difference.
// ============================================================================
//
//  channel   dir  modport  word
//  -------   ---  -------  ----------------------------------------------
//  i_pose    in   sink     frame x/y/heading, point x/y/heading
//  o_local   out  source   local x/y (Q16.16, clipped), heading, saturated
//
//  One word per cycle sustained while o_local is ready; the register stages are
//  difference, gain multiply, fold, one stage per micro-rotation, round.
//  Every stage holds its own valid bit; a stage loads whenever it is empty or
//  its successor moves, so bubbles close up and input is taken while a
//  finished word waits at o_local.
//  Synchronous active-low reset clears all valid bits; no other state.
//
`default_nettype none

module pose_frame_transform (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pft_in_if.sink    i_pose,
    pft_out_if.source o_local
);
    import pft_pkg::*;

    // CORDIC chain: index k feeds micro-rotation k
    logic vld [STEPS+1];
    logic rdy [STEPS+1];
    t_rot rot [STEPS+1];

    // difference, gain and quadrant fold
    pft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pose.valid),
        .i_pose  (i_pose.data),
        .o_ready (i_pose.ready),
        .o_valid (vld[0]),
        .o_rot   (rot[0]),
        .i_ready (rdy[0])
    );

    // one micro-rotation per stage; shift and arctangent fixed per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_rot
        pft_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(k)),
            .i_valid (vld[k]),
            .i_rot   (rot[k]),
            .o_ready (rdy[k]),
            .o_valid (vld[k+1]),
            .o_rot   (rot[k+1]),
            .i_ready (rdy[k+1])
        );
    end

    // rounding, clipping, output register
    pft_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld[STEPS]),
        .i_rot   (rot[STEPS]),
        .o_ready (rdy[STEPS]),
        .o_valid (o_local.valid),
        .o_data  (o_local.data),
        .i_ready (o_local.ready)
    );

    // nothing leaves right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_local.valid)
        else $error("output word valid right after reset");

    // input is refused only with every stage full and the output stalled
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pose.ready |-> (o_local.valid && !o_local.ready))
        else $error("input refused while the pipeline has room");

    // a clipped word sits at a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_local.valid && o_local.data.saturated) |->
            (o_local.data.local_x == 32'sh7FFFFFFF ||
             o_local.data.local_x == 32'sh80000000 ||
             o_local.data.local_y == 32'sh7FFFFFFF ||
             o_local.data.local_y == 32'sh80000000))
        else $error("saturated flag without a clipped position");

endmodule

`default_nettype wire

@@ test/tb_pose_frame_transform.sv @@
// ============================================================================
// tb_pose_frame_transform: self-checking bench for the pose frame transform
// Walks a table of directed poses, then random poses under three idle
// mixes and one long output hold-off; every local pose word is compared
// against the word typed into its directed row if any, else a bit-exact CORDIC predictor kept in the bench.
// ============================================================================
`default_nettype none

module tb_pose_frame_transform;

    import pft_pkg::t_pose_in;
    import pft_pkg::t_pose_out;

    localparam int ABITS        = pft_pkg::ANGLE_BITS;
    localparam int ROT_STEPS    = pft_pkg::STEPS;
    localparam int LATENCY      = 4 + pft_pkg::STEPS;
    localparam int N_DIRECTED   = 22;
    localparam int N_RANDOM     = 900;
    localparam int PHASE_LEN    = 300;
    localparam int HOLD_AT      = N_DIRECTED + 2 * PHASE_LEN + 50;
    localparam int HOLD_CYCLES  = 90;
    localparam int TIMEOUT_CYC  = 200000;
    localparam int REPORT_MAX   = 10;

    localparam longint CORDIC_GAIN_Q31 = 64'sd1304065748;
    localparam longint INT32_HI        = 64'sd2147483647;
    localparam longint INT32_LO        = -64'sd2147483648;

    localparam logic signed [31:0] P_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] P_MIN = 32'sh80000000;

    // atan(2^-i) as a 32-bit fraction of a turn
    localparam logic [31:0] ARCTAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic      typed;   // 1: compare against want, 0: use the predictor
        t_pose_out want;
    } t_typed_exp;

    typedef struct packed {
        t_pose_in   pose;
        t_typed_exp exp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    pft_in_if  in_ch ();
    pft_out_if out_ch ();

    pose_frame_transform DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (in_ch),
        .o_local (out_ch)
    );

    t_pose_out  local_pose_due [$];
    t_typed_exp typed_q [$];
    int         in_accepted  = 0;
    int         words_seen   = 0;
    int         sat_seen     = 0;
    int         mismatches   = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;

    // Directed table. Zero-difference rows have a result readable by eye:
    // positions stay zero, heading is the plain 16-bit difference.
    t_dir_row directed_rows [N_DIRECTED] = '{
        '{'{32'sh0, 32'sh0, 16'sh0, 32'sh0, 32'sh0, 16'sh0},
          '{1'b1, '{32'sh0, 32'sh0, 16'sh0, 1'b0}}},
        '{'{32'sh12345678, -32'sh0ABCDEF0, -16'sh8000, 32'sh12345678, -32'sh0ABCDEF0, 16'sh0},
          '{1'b1, '{32'sh0, 32'sh0, 16'sh8000, 1'b0}}},
        '{'{32'sh1, 32'sh1, 16'sh7FFF, 32'sh1, 32'sh1, -16'sh8000},
          '{1'b1, '{32'sh0, 32'sh0, 16'sh0001, 1'b0}}},
        '{'{-32'sh1, -32'sh1, -16'sh8000, -32'sh1, -32'sh1, 16'sh7FFF},
          '{1'b1, '{32'sh0, 32'sh0, 16'shFFFF, 1'b0}}},
        '{'{P_MAX, P_MAX, 16'sh4000, P_MAX, P_MAX, -16'sh4000},
          '{1'b1, '{32'sh0, 32'sh0, 16'sh8000, 1'b0}}},
        '{'{P_MIN, P_MIN, 16'sh0001, P_MIN, P_MIN, -16'sh8000},
          '{1'b1, '{32'sh0, 32'sh0, 16'sh7FFF, 1'b0}}},
        // full-scale differences, saturating one axis at a time
        '{'{P_MIN, 32'sh0, 16'sh0, P_MAX, 32'sh0, 16'sh0}, '0},
        '{'{P_MAX, 32'sh0, 16'sh0, P_MIN, 32'sh0, 16'sh0}, '0},
        '{'{32'sh0, P_MIN, 16'sh0, 32'sh0, P_MAX, 16'sh0}, '0},
        '{'{32'sh0, P_MAX, 16'sh0, 32'sh0, P_MIN, 16'sh0}, '0},
        // half-turn frame heading: negation wraps back to itself
        '{'{32'sh0, 32'sh0, -16'sh8000, 32'sh00010000, 32'sh0, 16'sh1234}, '0},
        // quarter-turn fold boundaries on both sides
        '{'{32'sh0, 32'sh0, 16'sh4000, 32'sh00030000, 32'sh00010000, 16'sh0}, '0},
        '{'{32'sh0, 32'sh0, -16'sh4000, 32'sh00030000, 32'sh00010000, 16'sh0}, '0},
        '{'{32'sh0, 32'sh0, 16'sh4001, 32'sh00030000, 32'sh00010000, 16'sh0}, '0},
        '{'{32'sh0, 32'sh0, -16'sh3FFF, 32'sh00030000, 32'sh00010000, 16'sh0}, '0},
        '{'{32'sh0, 32'sh0, 16'sh0001, 32'sh1, -32'sh1, 16'sh0}, '0},
        '{'{32'sh0, 32'sh0, -16'sh0001, P_MAX, P_MAX, 16'sh7FFF}, '0},
        '{'{-32'sh01000000, 32'sh00800000, 16'sh2000, 32'sh00200000, -32'sh00400000,
            -16'sh2000}, '0},
        '{'{P_MIN, P_MIN, 16'sh0, P_MAX, P_MAX, 16'sh0}, '0},
        '{'{P_MIN, P_MIN, -16'sh2000, P_MAX, P_MAX, 16'sh0}, '0},
        '{'{32'sh7FFF0000, -32'sh7FFF0000, 16'sh7FFF, -32'sh00008000, 32'sh00008000,
            -16'sh7FFF}, '0},
        '{'{P_MAX, P_MAX, -16'sh8000, P_MIN, P_MIN, 16'sh0}, '0}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint wrap_binang(input longint z);
        return (z <<< (64 - ABITS)) >>> (64 - ABITS);
    endfunction

    function automatic logic [31:0] clamp_pos(input longint v, inout logic clipped);
        if (v > INT32_HI) begin
            clipped = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < INT32_LO) begin
            clipped = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_pose_out local_pose_of(input t_pose_in p);
        longint     x, y, z, theta, xs, ys, a, quarter, half;
        logic [15:0] neg_h;
        logic [63:0] a_u;
        logic        clipped;
        t_pose_out   r;
        x = ((longint'($signed(p.point_x)) - longint'($signed(p.frame_x)))
             * CORDIC_GAIN_Q31) >>> 15;
        y = ((longint'($signed(p.point_y)) - longint'($signed(p.frame_y)))
             * CORDIC_GAIN_Q31) >>> 15;
        neg_h = -p.frame_heading;
        theta = longint'($signed(neg_h));
        if (ABITS >= 16)
            z = wrap_binang(theta <<< (ABITS - 16));
        else
            z = wrap_binang(theta >>> (16 - ABITS));
        // fold angles beyond a quarter turn by a half-turn flip
        quarter = 64'sd1 <<< (ABITS - 2);
        half    = 64'sd1 <<< (ABITS - 1);
        if (z >= quarter || z < -quarter) begin
            x = -x;
            y = -y;
            z = wrap_binang(z + half);
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            a_u = (64'(ARCTAN_TURN[i & 31]) + (64'd1 << (31 - ABITS))) >> (32 - ABITS);
            a   = longint'(a_u);
            xs  = x >>> i;
            ys  = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - a;
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + a;
            end
        end
        clipped         = 1'b0;
        r.local_x       = clamp_pos((x + 64'sd32768) >>> 16, clipped);
        r.local_y       = clamp_pos((y + 64'sd32768) >>> 16, clipped);
        r.local_heading = p.point_heading - p.frame_heading;
        r.saturated     = clipped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] corner_pos();
        case ($urandom_range(0, 4))
            0: return 32'h00000000;
            1: return 32'h00000001;
            2: return 32'hFFFFFFFF;
            3: return 32'h7FFFFFFF;
            default: return 32'h80000000;
        endcase
    endfunction

    function automatic logic [15:0] corner_heading();
        case ($urandom_range(0, 8))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3: return 16'h7FFF;
            4: return 16'h8000;
            5: return 16'h4000;
            6: return 16'hC000;
            7: return 16'h4001;
            default: return 16'hC001;
        endcase
    endfunction

    function automatic t_pose_in random_pose();
        t_pose_in    p;
        logic [19:0] dx, dy;
        int          kind;
        kind            = $urandom_range(0, 99);
        p.frame_x       = $urandom();
        p.frame_y       = $urandom();
        p.point_x       = $urandom();
        p.point_y       = $urandom();
        p.frame_heading = 16'($urandom());
        p.point_heading = 16'($urandom());
        if (kind >= 55 && kind < 85) begin
            // point close to the frame origin: no clipping, fine rotation error
            dx        = 20'($urandom());
            dy        = 20'($urandom());
            p.point_x = p.frame_x + {{12{dx[19]}}, dx};
            p.point_y = p.frame_y + {{12{dy[19]}}, dy};
        end else if (kind >= 85) begin
            p.frame_x       = corner_pos();
            p.frame_y       = corner_pos();
            p.point_x       = corner_pos();
            p.point_y       = corner_pos();
            p.frame_heading = corner_heading();
            p.point_heading = corner_heading();
        end
        return p;
    endfunction

    // idle mixes: 21/45, then 45/21, then none
    function automatic int send_idle_pct(input int n);
        if (n < N_DIRECTED + PHASE_LEN)     return 21;
        if (n < N_DIRECTED + 2 * PHASE_LEN) return 45;
        return 0;
    endfunction

    function automatic int recv_idle_pct(input int n);
        if (n < N_DIRECTED + PHASE_LEN)     return 45;
        if (n < N_DIRECTED + 2 * PHASE_LEN) return 21;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #(TIMEOUT_CYC * 10);
        $display("timeout: %0d local pose words still due", local_pose_due.size());
        $display("[pose_frame_transform] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        logic rdy;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && in_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                rdy = ($urandom_range(0, 99) >= recv_idle_pct(in_accepted));
            end
            out_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on input acceptance, check on output acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_typed_exp tex;
        t_pose_out  want;
        t_pose_out  got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                tex = typed_q.pop_front();
                local_pose_due.push_back(tex.typed ? tex.want : local_pose_of(in_ch.data));
                in_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                words_seen++;
                if (local_pose_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected word x=%h y=%h hd=%h sat=%b", $time,
                                 got.local_x, got.local_y, got.local_heading, got.saturated);
                end else begin
                    want = local_pose_due.pop_front();
                    if (got.local_x !== want.local_x || got.local_y !== want.local_y ||
                        got.local_heading !== want.local_heading ||
                        got.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: want x=%h y=%h hd=%h sat=%b, got x=%h y=%h hd=%h sat=%b",
                                     $time, want.local_x, want.local_y, want.local_heading,
                                     want.saturated, got.local_x, got.local_y,
                                     got.local_heading, got.saturated);
                    end else if (got.saturated) begin
                        sat_seen++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic offer_pose(input t_pose_in p, input t_typed_exp tex);
        typed_q.push_back(tex);
        while ($urandom_range(0, 99) < send_idle_pct(in_accepted)) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= p;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            offer_pose(directed_rows[r].pose, directed_rows[r].exp);
        for (int n = 0; n < N_RANDOM; n++)
            offer_pose(random_pose(), '0);
        in_ch.valid <= 1'b0;

        while (local_pose_due.size() != 0) @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);
        if (local_pose_due.size() != 0)
            mismatches++;

        $display("checked %0d local pose words (%0d directed rows, %0d clipped)",
                 words_seen, N_DIRECTED, sat_seen);
        $display("idle mixes 21/45, 45/21, none; one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("[pose_frame_transform] OK");
        end else begin
            $display("%0d mismatching words", mismatches);
            $display("[pose_frame_transform] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/pft_pkg.sv
hw/rtl/pft_channels.sv
hw/rtl/pft_front.sv
hw/rtl/pft_cordic_stage.sv
hw/rtl/pft_back.sv
hw/rtl/pose_frame_transform.sv
test/tb_pose_frame_transform.sv
